@@ hw/rtl/assert_macros.svh @@
// assertion macros for the rtl folder
// each macro needs a clk and rst in scope
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// property checked at every clock edge outside reset
`define CHK_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error("check failed");
// property checked during reset too
`define CHK_RESET(lbl, prop) \
  lbl: assert property (@(posedge clk) (prop)) else $error("check failed");
`endif

@@ hw/rtl/fkah_pkg.sv @@
// fixed-key aes hash package: sbox table and round helper functions
// no dependencies
`default_nettype none
package fkah_pkg;

  localparam logic [7:0] SBOX [256] = '{
    8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
    8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
    8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
    8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
    8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
    8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
    8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
    8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
    8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
    8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
    8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
    8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
    8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
    8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
    8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
    8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
  };

  localparam logic [3:0] LAST_ROUND = 4'd10;
  localparam logic [3:0] LAST_DIGIT = 4'd15;

  function automatic logic [7:0] xtime(input logic [7:0] a);
    xtime = {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
  endfunction

  function automatic logic [127:0] shift_rows(input logic [127:0] s);
    logic [127:0] t;
    t = '0;
    for (int c = 0; c < 4; c++) begin
      for (int n = 0; n < 4; n++) begin
        t[8*(n+4*c) +: 8] = s[8*(n+4*((c+n)%4)) +: 8];
      end
    end
    shift_rows = t;
  endfunction

  function automatic logic [127:0] mix_columns(input logic [127:0] s);
    logic [127:0] t;
    logic [7:0] a0, a1, a2, a3, al;
    t = '0;
    for (int c = 0; c < 4; c++) begin
      a0 = s[32*c +: 8];
      a1 = s[32*c+8 +: 8];
      a2 = s[32*c+16 +: 8];
      a3 = s[32*c+24 +: 8];
      al = a0 ^ a1 ^ a2 ^ a3;
      t[32*c +: 8]    = a0 ^ al ^ xtime(a0 ^ a1);
      t[32*c+8 +: 8]  = a1 ^ al ^ xtime(a1 ^ a2);
      t[32*c+16 +: 8] = a2 ^ al ^ xtime(a2 ^ a3);
      t[32*c+24 +: 8] = a3 ^ al ^ xtime(a3 ^ a0);
    end
    mix_columns = t;
  endfunction

endpackage
`default_nettype wire

@@ hw/rtl/fixed_key_aes_tweakable_hash.sv @@
// top level: fixed-key aes-128 tweakable hash, H = E(E(x) ^ t) ^ E(x)
// depends on fkah_pkg and assert_macros.svh
//
//  channel | signals                                   | role
//  in      | in_valid in_ready block_* tweak_* last    | block and tweak
//  out     | out_valid out_ready hash_* result_last    | hash result
//  cfg     | psel penable pwrite paddr pwdata prdata   | key registers
//
// one byte a cycle goes through the sbox: a substitution state that covers all state bytes plus
// a round-finish state per round, 10 rounds per pass, two passes
// an item goes through a load, the rounds of both passes and a handoff before it can leave
// the next item is taken once the result sits in the output register
// a stalled output holds the engine in its handoff state; reset is synchronous
`default_nettype none
`include "assert_macros.svh"
module fixed_key_aes_tweakable_hash (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [63:0] block_low,
  input  wire logic [63:0] block_high,
  input  wire logic [63:0] tweak_low,
  input  wire logic [63:0] tweak_high,
  input  wire logic        block_last,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [63:0]      hash_low,
  output logic [63:0]      hash_high,
  output logic             result_last,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [3:0]  paddr,
  input  wire logic [63:0] pwdata,
  output logic [63:0]      prdata,
  output logic             pready
);
  import fkah_pkg::*;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_SUB  = 2'd1;
  localparam logic [1:0] ST_FIN  = 2'd2;
  localparam logic [1:0] ST_HOLD = 2'd3;

  logic [1:0]   state;
  logic [3:0]   digit;
  logic [3:0]   rnd;
  logic         pass;
  logic [7:0]   rcon;
  logic [127:0] sreg;
  logic [127:0] rk;
  logic [31:0]  tw;
  logic [127:0] ex;
  logic [127:0] tweak;
  logic         last;
  logic [63:0]  key_low;
  logic [63:0]  key_high;

  logic [127:0] key;
  logic [7:0]   key_byte;
  logic [127:0] nk;
  logic [127:0] sr;
  logic [127:0] s_next;
  logic [31:0]  w0, w1, w2, w3;
  logic         out_free;

  assign key      = {key_high, key_low};
  assign pready   = 1'b1;
  assign prdata   = paddr[3] ? key_high : key_low;
  assign in_ready = (state == ST_IDLE);
  assign out_free = !out_valid || out_ready;

  // word 3 byte order for rotword: 1, 2, 3, 0
  assign key_byte = rk[96 + 8*{digit[1:0] + 2'd1} +: 8];

  assign w0 = rk[31:0] ^ {tw[31:8], tw[7:0] ^ rcon};
  assign w1 = rk[63:32] ^ w0;
  assign w2 = rk[95:64] ^ w1;
  assign w3 = rk[127:96] ^ w2;
  assign nk = {w3, w2, w1, w0};
  assign sr = shift_rows(sreg);
  assign s_next = ((rnd == LAST_ROUND) ? sr : mix_columns(sr)) ^ nk;

  always_ff @(posedge clk) begin
    if (rst) begin
      key_low  <= '0;
      key_high <= '0;
    end else if (psel && penable && pwrite && pready) begin
      if (paddr[3]) key_high <= pwdata;
      else          key_low  <= pwdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
      digit     <= '0;
      rnd       <= '0;
      pass      <= 1'b0;
    end else begin
      if (out_valid && out_ready && state != ST_HOLD) out_valid <= 1'b0;
      unique case (state)
        ST_IDLE: begin
          if (in_valid) begin
            sreg  <= {block_high, block_low} ^ key;
            rk    <= key;
            tweak <= {tweak_high, tweak_low};
            last  <= block_last;
            rnd   <= 4'd1;
            rcon  <= 8'h01;
            pass  <= 1'b0;
            digit <= '0;
            state <= ST_SUB;
          end
        end
        ST_SUB: begin
          sreg <= {SBOX[sreg[7:0]], sreg[127:8]};
          if (digit < 4'd4) tw <= {SBOX[key_byte], tw[31:8]};
          digit <= digit + 4'd1;
          if (digit == LAST_DIGIT) state <= ST_FIN;
        end
        ST_FIN: begin
          digit <= '0;
          if (rnd != LAST_ROUND) begin
            rcon  <= xtime(rcon);
            rk    <= nk;
            rnd   <= rnd + 4'd1;
            sreg  <= s_next;
            state <= ST_SUB;
          end else if (!pass) begin
            ex    <= s_next;
            sreg  <= s_next ^ tweak ^ key;
            rk    <= key;
            rnd   <= 4'd1;
            rcon  <= 8'h01;
            pass  <= 1'b1;
            state <= ST_SUB;
          end else begin
            sreg  <= s_next ^ ex;
            state <= ST_HOLD;
          end
        end
        ST_HOLD: begin
          if (out_free) begin
            hash_low    <= sreg[63:0];
            hash_high   <= sreg[127:64];
            result_last <= last;
            out_valid   <= 1'b1;
            state       <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  `CHK_ALWAYS(ready_only_idle, in_ready |-> (state == ST_IDLE))
  `CHK_ALWAYS(round_in_range, (state == ST_SUB) |-> (rnd >= 4'd1 && rnd <= LAST_ROUND))
  `CHK_ALWAYS(hold_waits_out, (state == ST_HOLD && !out_free) |=> (state == ST_HOLD))
  `CHK_ALWAYS(out_stall_holds, (out_valid && !out_ready) |=> (out_valid && $stable(hash_low)))

endmodule
`default_nettype wire

@@ bench/tb.sv @@
// self-checking bench for fixed_key_aes_tweakable_hash: directed table, then random phases
// holds its own aes-128 hash predictor; uses SBOX from fkah_pkg, needs only the rtl
`default_nettype none
module tb;
  import fkah_pkg::*;

  typedef struct packed {
    logic [63:0] lo;
    logic [63:0] hi;
    logic        last;
  } hash_t;

  typedef struct {
    logic [63:0] key_lo;
    logic [63:0] key_hi;
    logic [63:0] blk_lo;
    logic [63:0] blk_hi;
    logic [63:0] twk_lo;
    logic [63:0] twk_hi;
    logic        last;
  } row_t;

  localparam logic [7:0] RCON [10] = '{8'h01, 8'h02, 8'h04, 8'h08, 8'h10,
                                       8'h20, 8'h40, 8'h80, 8'h1b, 8'h36};
  localparam logic [3:0] ADDR_KEY_LOW  = 4'd0;
  localparam logic [3:0] ADDR_KEY_HIGH = 4'd8;
  localparam int WATCHDOG_LIMIT = 6000;
  localparam int HOLD_CYCLES    = 1500;
  localparam int DRAIN_CYCLES   = 400;
  localparam int ITEMS_PER_PHASE = 175;

  logic clk, rst;
  logic in_valid, in_ready, out_valid, out_ready;
  logic [63:0] block_low, block_high, tweak_low, tweak_high;
  logic block_last;
  logic [63:0] hash_low, hash_high;
  logic result_last;
  logic psel, penable, pwrite, pready;
  logic [3:0] paddr;
  logic [63:0] pwdata, prdata;

  fixed_key_aes_tweakable_hash i_dut (
    .clk, .rst, .in_valid, .in_ready, .block_low, .block_high, .tweak_low, .tweak_high,
    .block_last, .out_valid, .out_ready, .hash_low, .hash_high, .result_last,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  logic [127:0] key_now;
  hash_t pending_hashes [$];
  int errors = 0;
  int items_sent = 0;
  int hashes_seen = 0;
  int key_writes = 0;
  int idle_pct = 0;
  int stall_pct = 0;
  bit hold_req = 0;
  int quiet_cycles = 0;

  function automatic logic [7:0] dbl(input logic [7:0] a);
    dbl = {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
  endfunction

  function automatic logic [127:0] aes_encrypt(input logic [127:0] key, input logic [127:0] pt);
    logic [127:0] rk [11];
    logic [31:0] w [44];
    logic [31:0] t;
    logic [127:0] s, u;
    logic [7:0] a0, a1, a2, a3, al;
    for (int i = 0; i < 4; i++) w[i] = key[32*i +: 32];
    for (int i = 4; i < 44; i++) begin
      t = w[i-1];
      if (i % 4 == 0)
        t = {SBOX[t[7:0]], SBOX[t[31:24]], SBOX[t[23:16]], SBOX[t[15:8]] ^ RCON[i/4-1]};
      w[i] = w[i-4] ^ t;
    end
    for (int r = 0; r < 11; r++) rk[r] = {w[4*r+3], w[4*r+2], w[4*r+1], w[4*r]};
    s = pt ^ rk[0];
    for (int r = 1; r <= 10; r++) begin
      for (int c = 0; c < 4; c++)
        for (int n = 0; n < 4; n++)
          u[8*(n+4*c) +: 8] = SBOX[s[8*(n+4*((c+n)%4)) +: 8]];
      if (r < 10) begin
        for (int c = 0; c < 4; c++) begin
          a0 = u[32*c +: 8];
          a1 = u[32*c+8 +: 8];
          a2 = u[32*c+16 +: 8];
          a3 = u[32*c+24 +: 8];
          al = a0 ^ a1 ^ a2 ^ a3;
          u[32*c +: 8]    = a0 ^ al ^ dbl(a0 ^ a1);
          u[32*c+8 +: 8]  = a1 ^ al ^ dbl(a1 ^ a2);
          u[32*c+16 +: 8] = a2 ^ al ^ dbl(a2 ^ a3);
          u[32*c+24 +: 8] = a3 ^ al ^ dbl(a3 ^ a0);
        end
      end
      s = u ^ rk[r];
    end
    aes_encrypt = s;
  endfunction

  function automatic hash_t tweak_hash(input logic [127:0] x, input logic [127:0] tw,
                                       input logic last);
    logic [127:0] ex, h;
    hash_t res;
    ex = aes_encrypt(key_now, x);
    h = aes_encrypt(key_now, ex ^ tw) ^ ex;
    res.lo = h[63:0];
    res.hi = h[127:64];
    res.last = last;
    tweak_hash = res;
  endfunction

  function automatic logic [63:0] rand64();
    case ($urandom_range(9))
      0: rand64 = '0;
      1: rand64 = '1;
      default: rand64 = {$urandom, $urandom};
    endcase
  endfunction

  task automatic wait_drained();
    while (pending_hashes.size() != 0) @(posedge clk);
  endtask

  task automatic apb_write(input logic [3:0] addr, input logic [63:0] data);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= addr;
    pwdata <= data;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    key_writes++;
  endtask

  task automatic load_key(input logic [63:0] lo, input logic [63:0] hi);
    in_valid <= 1'b0;
    wait_drained();
    apb_write(ADDR_KEY_LOW, lo);
    apb_write(ADDR_KEY_HIGH, hi);
    key_now = {hi, lo};
  endtask

  task automatic send_block(input logic [63:0] blo, input logic [63:0] bhi,
                            input logic [63:0] tlo, input logic [63:0] thi, input logic last);
    in_valid <= 1'b1;
    block_low <= blo;
    block_high <= bhi;
    tweak_low <= tlo;
    tweak_high <= thi;
    block_last <= last;
    do @(posedge clk); while (!in_ready);
    pending_hashes.push_back(tweak_hash({bhi, blo}, {thi, tlo}, last));
    items_sent++;
    if (idle_pct > 0 && $urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < idle_pct);
    end
  endtask

  // receiver: random stall plus long hold-off on request
  initial begin
    int hold_left;
    hash_t want;
    hold_left = 0;
    out_ready = 1'b0;
    forever begin
      @(posedge clk);
      if (out_valid && out_ready) begin
        hashes_seen++;
        if (pending_hashes.size() == 0) begin
          $display("%0t: unexpected hash %h_%h last %b", $time, hash_high, hash_low,
                   result_last);
          errors++;
        end else begin
          want = pending_hashes.pop_front();
          if (hash_low !== want.lo || hash_high !== want.hi || result_last !== want.last) begin
            $display("%0t: hash mismatch expected %h_%h last %b actual %h_%h last %b", $time,
                     want.hi, want.lo, want.last, hash_high, hash_low, result_last);
            errors++;
          end
        end
      end
      if (hold_req) begin
        hold_req = 0;
        hold_left = HOLD_CYCLES;
      end
      if (rst) begin
        out_ready <= 1'b0;
      end else if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= ($urandom_range(99) >= stall_pct);
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || rst) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: no transfer for %0d cycles", $time, WATCHDOG_LIMIT);
      $display("tb: failure");
      $finish;
    end
  end

  row_t directed [] = '{
    '{64'h0, 64'h0, 64'h0, 64'h0, 64'h0, 64'h0, 1'b0},
    '{64'h0, 64'h0, '1, '1, '1, '1, 1'b1},
    '{64'h0, 64'h0, 64'h5555_5555_5555_5555, 64'haaaa_aaaa_aaaa_aaaa, 64'h1, 64'h0, 1'b0},
    '{'1, '1, 64'h0, 64'h0, 64'h0, 64'h0, 1'b1},
    '{'1, '1, '1, '1, 64'h0, 64'h0, 1'b0},
    '{'1, '1, 64'h0123_4567_89ab_cdef, 64'hfedc_ba98_7654_3210, 64'h0, 64'h8000_0000_0000_0000,
      1'b1},
    '{64'h0706050403020100, 64'h0f0e0d0c0b0a0908, 64'h7766554433221100, 64'hffeeddccbbaa9988,
      64'h0, 64'h0, 1'b0},
    '{64'h0706050403020100, 64'h0f0e0d0c0b0a0908, 64'h7766554433221100, 64'hffeeddccbbaa9988,
      64'h1, 64'h0, 1'b0},
    '{64'h0706050403020100, 64'h0f0e0d0c0b0a0908, 64'h7766554433221100, 64'hffeeddccbbaa9988,
      64'h2, 64'h0, 1'b1},
    '{64'h8000_0000_0000_0001, 64'h8000_0000_0000_0001, '1, 64'h0, '1, 64'h0, 1'b1},
    '{64'h8000_0000_0000_0001, 64'h8000_0000_0000_0001, 64'h0, '1, 64'h0, '1, 1'b0},
    '{64'h0, '1, 64'hdead_beef_0000_ffff, 64'h0, 64'hffff_ffff_ffff_ffff, 64'h1, 1'b1}
  };

  initial begin
    logic [127:0] kat;
    logic [63:0] batch_base, blo, bhi;
    int batch_len, j;
    bit paused;
    rst = 1'b1;
    in_valid = 1'b0;
    block_low = '0;
    block_high = '0;
    tweak_low = '0;
    tweak_high = '0;
    block_last = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    key_now = '0;
    kat = aes_encrypt(128'h0f0e0d0c0b0a0908_0706050403020100,
                      128'hffeeddccbbaa9988_7766554433221100);
    if (kat !== 128'h5ac5b47080b7cdd8_30047b6ad8e0c469) begin
      $display("%0t: aes predictor mismatch expected %h actual %h", $time,
               128'h5ac5b47080b7cdd8_30047b6ad8e0c469, kat);
      errors++;
    end
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // first rows run under the reset key
    foreach (directed[k]) begin
      if ({directed[k].key_hi, directed[k].key_lo} !== key_now)
        load_key(directed[k].key_lo, directed[k].key_hi);
      send_block(directed[k].blk_lo, directed[k].blk_hi, directed[k].twk_lo,
                 directed[k].twk_hi, directed[k].last);
    end

    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: load_key('1, '1);
        1: load_key('0, '0);
        default: load_key({$urandom, $urandom}, {$urandom, $urandom});
      endcase
      case (ph)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 70; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 70; end
        default: begin idle_pct = 13; stall_pct = 13; end
      endcase
      if (ph == 0) hold_req = 1;
      j = 0;
      paused = 0;
      while (j < ITEMS_PER_PHASE) begin
        if (ph == 1 && j >= ITEMS_PER_PHASE / 2 && !paused) begin
          paused = 1;
          in_valid <= 1'b0;
          wait_drained();
        end
        if ($urandom_range(3) != 0) begin
          // multi-block batch: tweak counts up, high tweak zero, last on final block
          batch_len = $urandom_range(1, 8);
          batch_base = ($urandom_range(4) == 0) ? ~64'h0 - 64'd3 : {32'h0, $urandom};
          blo = rand64();
          bhi = rand64();
          for (int b = 0; b < batch_len; b++) begin
            send_block(blo ^ 64'(b), bhi, batch_base + 64'(b), 64'h0, b == batch_len - 1);
            blo = rand64();
            bhi = rand64();
          end
          j += batch_len;
        end else begin
          send_block(rand64(), rand64(), rand64(), rand64(), 1'($urandom_range(1)));
          j++;
        end
      end
    end

    in_valid <= 1'b0;
    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("covered %0d blocks, %0d hashes checked, %0d key register writes", items_sent,
             hashes_seen, key_writes);
    $display("idle and stall mixes: none, sender 70%%, receiver 70%%, both 13%%, long hold-off");
    if (errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end
endmodule
`default_nettype wire

@@ fixed_key_aes_tweakable_hash.f @@
+incdir+hw/rtl
hw/rtl/fkah_pkg.sv
hw/rtl/fixed_key_aes_tweakable_hash.sv
bench/tb.sv
